// ===== rtl/adc_avg_pkg.sv =====
`default_nettype none

package adc_avg_pkg;

  localparam int WIN_DEPTH = 40;
  localparam int ADC_W = 24;
  localparam int SAMPLE_W = 26;
  localparam int SUM_W = 32;
  localparam int NUM_RANGES = 4;
  localparam int RANGE_W = 2;
  localparam int CFG_IDX_W = 4;
  localparam int JUMP_LIMIT = 10000;

  localparam logic [RANGE_W-1:0] RANGE_TOP = RANGE_W'(NUM_RANGES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_RANGE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR = 4'd7;

  localparam logic [SUM_W-1:0] UP_LIM_RST = SUM_W'(64'd6000000 * WIN_DEPTH);
  localparam logic [SUM_W-1:0] DOWN_LIM_RST = SUM_W'(64'd40000 * WIN_DEPTH);

  // mean = |sum| * recip >> shift, exact for |sum| < 2^(SUM_W-1)
  localparam int DIV_SHIFT = SUM_W - 1 + $clog2(WIN_DEPTH);
  localparam logic [63:0] DivRecipFull =
      ((64'd1 << DIV_SHIFT) + 64'(WIN_DEPTH) - 64'd1) / WIN_DEPTH;
  localparam logic [SUM_W-1:0] DIV_RECIP = DivRecipFull[SUM_W-1:0];

  // thresholds are held pre-scaled by the window depth
  typedef struct packed {
    logic [NUM_RANGES-1:0][ADC_W-1:0] zero_offset;
    logic                             auto_mode;
    logic [SUM_W-1:0]                 up_lim;
    logic [SUM_W-1:0]                 down_lim;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/adc_avg_cell.sv =====
`default_nettype none

module adc_avg_cell (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         en_i,
  input  wire                                         refill_i,
  input  wire  logic signed [adc_avg_pkg::SAMPLE_W-1:0] refill_data_i,
  input  wire  logic signed [adc_avg_pkg::SAMPLE_W-1:0] shift_i,
  output logic signed [adc_avg_pkg::SAMPLE_W-1:0]       q_o
);

  logic signed [adc_avg_pkg::SAMPLE_W-1:0] entry_q;
  logic signed [adc_avg_pkg::SAMPLE_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (en_i) begin
      entry_d = refill_i ? refill_data_i : shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/adc_avg_cfg.sv =====
`default_nettype none

module adc_avg_cfg (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  [adc_avg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [adc_avg_pkg::ADC_W-1:0]          cfg_data_i,
  output adc_avg_pkg::cfg_t                      cfg_o,
  output logic                                   range_wr_o,
  output logic [adc_avg_pkg::RANGE_W-1:0]        range_o
);

  adc_avg_pkg::cfg_t cfg_q;
  adc_avg_pkg::cfg_t cfg_d;
  logic              wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    range_wr_o = 1'b0;
    range_o = cfg_data_i[adc_avg_pkg::RANGE_W-1:0];
    if (wr) begin
      case (cfg_index_i)
        adc_avg_pkg::REG_ZERO_OFF0, adc_avg_pkg::REG_ZERO_OFF1,
        adc_avg_pkg::REG_ZERO_OFF2, adc_avg_pkg::REG_ZERO_OFF3: begin
          cfg_d.zero_offset[cfg_index_i[adc_avg_pkg::RANGE_W-1:0]] = cfg_data_i;
        end
        adc_avg_pkg::REG_AUTO_MODE: begin
          cfg_d.auto_mode = cfg_data_i[0];
        end
        adc_avg_pkg::REG_MANUAL_RANGE: begin
          range_wr_o = 1'b1;
        end
        adc_avg_pkg::REG_UP_THR: begin
          cfg_d.up_lim = adc_avg_pkg::SUM_W'(cfg_data_i) *
                         adc_avg_pkg::SUM_W'(adc_avg_pkg::WIN_DEPTH);
        end
        adc_avg_pkg::REG_DOWN_THR: begin
          cfg_d.down_lim = adc_avg_pkg::SUM_W'(cfg_data_i) *
                           adc_avg_pkg::SUM_W'(adc_avg_pkg::WIN_DEPTH);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_offset <= '0;
      cfg_q.auto_mode <= 1'b1;
      cfg_q.up_lim <= adc_avg_pkg::UP_LIM_RST;
      cfg_q.down_lim <= adc_avg_pkg::DOWN_LIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/adc_avg_div.sv =====
`default_nettype none

module adc_avg_div (
  input  wire  logic signed [adc_avg_pkg::SUM_W-1:0]    sum_i,
  output logic signed [adc_avg_pkg::SAMPLE_W-1:0]       mean_o
);

  localparam int MagW = adc_avg_pkg::SUM_W - 1;
  localparam int ProdW = MagW + adc_avg_pkg::SUM_W;

  logic                                   neg;
  logic [adc_avg_pkg::SUM_W-1:0]          abs_full;
  logic [MagW-1:0]                        mag;
  logic [ProdW-1:0]                       prod;
  logic [adc_avg_pkg::SAMPLE_W-1:0]       quot;

  always_comb begin
    neg = sum_i[adc_avg_pkg::SUM_W-1];
    abs_full = neg ? (~sum_i + 1'b1) : sum_i;
    mag = abs_full[MagW-1:0];
    prod = ProdW'(mag) * ProdW'(adc_avg_pkg::DIV_RECIP);
    quot = prod[adc_avg_pkg::DIV_SHIFT +: adc_avg_pkg::SAMPLE_W];
    mean_o = neg ? $signed(~quot + 1'b1) : $signed(quot);
  end

endmodule

`default_nettype wire

// ===== rtl/adc_average_autorange.sv =====
`default_nettype none

// Moving average over a 40-sample window with automatic gain ranging.
// Each item is one 24-bit offset-binary converter code; it is recentred,
// corrected by the zero offset of the range in force, and shifted into a
// row of window cells, or loads every cell when it lies more than 10000
// away from the last mean. One result (mean truncated toward zero, range
// after the item, range step flag) comes out per item, via the sum stage and
// then the output register. One item is taken every cycle unless the input is
// stalled: the running sum register and the range register close the only
// loop, and the mean divide sits in the output stage. Configuration writes
// are meant for idle periods only.
module adc_average_autorange (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire  [adc_avg_pkg::ADC_W-1:0]          adc_code_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [adc_avg_pkg::SAMPLE_W-1:0] average_o,
  output logic [adc_avg_pkg::RANGE_W-1:0]        range_o,
  output logic                                   range_changed_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  [adc_avg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [adc_avg_pkg::ADC_W-1:0]          cfg_data_i
);

  localparam int SW = adc_avg_pkg::SAMPLE_W;
  localparam int KW = adc_avg_pkg::SAMPLE_W + 1;
  localparam int UW = adc_avg_pkg::SUM_W;
  localparam int Depth = adc_avg_pkg::WIN_DEPTH;

  adc_avg_pkg::cfg_t                 cfg;
  logic                              range_wr;
  logic [adc_avg_pkg::RANGE_W-1:0]   range_wdata;

  logic signed [SW-1:0] win_val [Depth];
  logic signed [SW-1:0] code_c;
  logic signed [SW-1:0] off_s;
  logic signed [SW-1:0] sample;
  logic signed [KW-1:0] k_hi;
  logic signed [KW-1:0] k_lo;
  logic signed [UW-1:0] m_hi;
  logic signed [UW-1:0] m_lo;
  logic signed [UW-1:0] sample40;
  logic signed [UW-1:0] eff;
  logic                 jump;
  logic                 in_acc;
  logic                 up_hit;
  logic                 down_hit;
  logic [adc_avg_pkg::RANGE_W-1:0] r_up;
  logic [adc_avg_pkg::RANGE_W-1:0] r_new;

  logic signed [UW-1:0]            sum_q, sum_d;
  logic [adc_avg_pkg::RANGE_W-1:0] range_q, range_d;
  logic                            changed_q, changed_d;
  logic                            s1_valid_q, s1_valid_d;
  logic                            s1_adv;

  logic                            out_valid_q, out_valid_d;
  logic signed [SW-1:0]            average_q, average_d;
  logic [adc_avg_pkg::RANGE_W-1:0] range_out_q, range_out_d;
  logic                            changed_out_q, changed_out_d;
  logic signed [SW-1:0]            mean;

  adc_avg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .range_wr_o  (range_wr),
    .range_o     (range_wdata)
  );

  assign s1_adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc = in_valid_i && !in_stall_o;

  // offset binary to two's complement, then zero offset of the current range
  always_comb begin
    code_c = SW'($signed({~adc_code_i[adc_avg_pkg::ADC_W-1],
                          adc_code_i[adc_avg_pkg::ADC_W-2:0]}));
    off_s = SW'($signed(cfg.zero_offset[range_q]));
    sample = code_c - off_s;
  end

  // |trunc(sum/D) - s| > limit, tested on the sum itself
  always_comb begin
    k_hi = KW'(sample) + KW'(adc_avg_pkg::JUMP_LIMIT + 1);
    k_lo = KW'(sample) - KW'(adc_avg_pkg::JUMP_LIMIT);
    m_hi = UW'(k_hi) * UW'(Depth) - ((k_hi <= 0) ? UW'(Depth - 1) : UW'(0));
    m_lo = UW'(k_lo) * UW'(Depth) - ((k_lo <= 0) ? UW'(Depth - 1) : UW'(0));
    jump = (sum_q >= m_hi) || (sum_q < m_lo);
    sample40 = UW'(sample) * UW'(Depth);
    sum_d = sum_q;
    if (in_acc) begin
      sum_d = jump ? sample40 : sum_q - UW'(win_val[Depth-1]) + UW'(sample);
    end
  end

  always_comb begin
    eff = (sum_d <= 0) ? UW'(Depth) : sum_d;
    up_hit = $unsigned(eff) >= cfg.up_lim;
    down_hit = $unsigned(eff) < cfg.down_lim;
    r_up = range_q;
    if (cfg.auto_mode && up_hit && range_q != adc_avg_pkg::RANGE_TOP) begin
      r_up = range_q + 1'b1;
    end
    r_new = r_up;
    if (cfg.auto_mode && down_hit && r_up != '0) begin
      r_new = r_up - 1'b1;
    end
    range_d = range_q;
    changed_d = changed_q;
    if (in_acc) begin
      range_d = r_new;
      changed_d = r_new != range_q;
    end
    if (range_wr) begin
      range_d = range_wdata;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_win
    if (i == 0) begin : g_head
      adc_avg_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .en_i          (in_acc),
        .refill_i      (jump),
        .refill_data_i (sample),
        .shift_i       (sample),
        .q_o           (win_val[i])
      );
    end else begin : g_body
      adc_avg_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .en_i          (in_acc),
        .refill_i      (jump),
        .refill_data_i (sample),
        .shift_i       (win_val[i-1]),
        .q_o           (win_val[i])
      );
    end
  end

  adc_avg_div u_div (
    .sum_i  (sum_q),
    .mean_o (mean)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    average_d = average_q;
    range_out_d = range_out_q;
    changed_out_d = changed_out_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        average_d = mean;
        range_out_d = range_q;
        changed_out_d = changed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      range_q <= '0;
      changed_q <= 1'b0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      range_q <= range_d;
      changed_q <= changed_d;
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    average_q <= average_d;
    range_out_q <= range_out_d;
    changed_out_q <= changed_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign average_o = average_q;
  assign range_o = range_out_q;
  assign range_changed_o = changed_out_q;

`ifndef SYNTHESIS
  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item did not reach the sum stage");

  a_refill_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && jump) |=> (sum_q == $past(sample40)))
    else $error("window refill left a wrong running sum");

  a_range_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !range_wr) |=> (range_q == $past(range_q) ||
                               range_q == $past(range_q) + 2'd1 ||
                               range_q == $past(range_q) - 2'd1))
    else $error("range moved by more than one step");

  a_manual_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg.auto_mode && !range_wr) |=> $stable(range_q))
    else $error("range changed while auto mode is off");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MIDSCALE = 64'h800000;
  localparam logic [adc_avg_pkg::ADC_W-1:0] CODE_MAX = '1;
  localparam logic [adc_avg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO =
      adc_avg_pkg::REG_DOWN_THR + 1'b1;
  localparam logic [adc_avg_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef struct {
    logic signed [adc_avg_pkg::SAMPLE_W-1:0] mean;
    logic [adc_avg_pkg::RANGE_W-1:0]         rng;
    logic                                    stepped;
  } result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [adc_avg_pkg::ADC_W-1:0] adc_code_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [adc_avg_pkg::SAMPLE_W-1:0] average_o;
  logic [adc_avg_pkg::RANGE_W-1:0] range_o;
  logic range_changed_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [adc_avg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [adc_avg_pkg::ADC_W-1:0] cfg_data_i = '0;

  // averager state as the block should hold it
  longint win [adc_avg_pkg::WIN_DEPTH];
  longint win_sum = 0;
  longint last_mean = 0;
  bit [adc_avg_pkg::RANGE_W-1:0] cur_range = '0;
  longint zoff [adc_avg_pkg::NUM_RANGES];
  bit auto_en = 1'b1;
  longint up_lvl = 6000000;
  longint down_lvl = 40000;

  logic [adc_avg_pkg::ADC_W-1:0] code_q [$];
  result_t expected_q [$];
  int errors = 0;
  int items_checked = 0;
  int range_steps = 0;
  int settings_used = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int burst_left = 0;
  int gap_left = 0;

  adc_average_autorange uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .adc_code_i     (adc_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .average_o      (average_o),
    .range_o        (range_o),
    .range_changed_o(range_changed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void apply_reg(input logic [adc_avg_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [adc_avg_pkg::ADC_W-1:0] data);
    case (idx)
      adc_avg_pkg::REG_ZERO_OFF0: zoff[0] = longint'(signed'(data));
      adc_avg_pkg::REG_ZERO_OFF1: zoff[1] = longint'(signed'(data));
      adc_avg_pkg::REG_ZERO_OFF2: zoff[2] = longint'(signed'(data));
      adc_avg_pkg::REG_ZERO_OFF3: zoff[3] = longint'(signed'(data));
      adc_avg_pkg::REG_AUTO_MODE: auto_en = data[0];
      adc_avg_pkg::REG_MANUAL_RANGE: cur_range = data[adc_avg_pkg::RANGE_W-1:0];
      adc_avg_pkg::REG_UP_THR: up_lvl = longint'(data);
      adc_avg_pkg::REG_DOWN_THR: down_lvl = longint'(data);
      default: ;
    endcase
  endfunction

  function automatic result_t step_average(input logic [adc_avg_pkg::ADC_W-1:0] code);
    longint sample, gap, level;
    bit [adc_avg_pkg::RANGE_W-1:0] prior;
    result_t r;
    int k;
    prior = cur_range;
    sample = longint'(code) - MIDSCALE - zoff[cur_range];
    gap = last_mean - sample;
    if (gap < 0) gap = -gap;
    if (gap > adc_avg_pkg::JUMP_LIMIT) begin
      for (k = 0; k < adc_avg_pkg::WIN_DEPTH; k++) win[k] = sample;
      win_sum = sample * adc_avg_pkg::WIN_DEPTH;
    end else begin
      win_sum -= win[adc_avg_pkg::WIN_DEPTH-1];
      for (k = adc_avg_pkg::WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = sample;
      win_sum += sample;
    end
    last_mean = win_sum / adc_avg_pkg::WIN_DEPTH;
    if (auto_en) begin
      // non-positive sum ranges as a mean of one
      level = (win_sum <= 0) ? longint'(adc_avg_pkg::WIN_DEPTH) : win_sum;
      if (level >= adc_avg_pkg::WIN_DEPTH * up_lvl && cur_range < adc_avg_pkg::RANGE_TOP)
        cur_range++;
      if (level < adc_avg_pkg::WIN_DEPTH * down_lvl && cur_range > 0) cur_range--;
    end
    r.mean = last_mean[adc_avg_pkg::SAMPLE_W-1:0];
    r.rng = cur_range;
    r.stepped = (cur_range != prior);
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_stall_o === 1'b0) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (code_q.size() > 0) begin
        in_valid_i <= 1'b1;
        adc_code_i <= code_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in stretches, plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < hold_reqs) begin
        hold_left = 300;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE: out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HALF: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // register writes, accepted items and results
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o === 1'b1) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_stall_o === 1'b0) expected_q.push_back(step_average(adc_code_i));
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending: average %0d", average_o);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          items_checked++;
          if (exp_r.stepped) range_steps++;
          if (average_o !== exp_r.mean) begin
            $error("average: expected %0d, got %0d", exp_r.mean, average_o);
            errors++;
          end
          if (range_o !== exp_r.rng) begin
            $error("range: expected %0d, got %0d", exp_r.rng, range_o);
            errors++;
          end
          if (range_changed_o !== exp_r.stepped) begin
            $error("range_changed: expected %0b, got %0b", exp_r.stepped, range_changed_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [adc_avg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adc_avg_pkg::ADC_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (code_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [adc_avg_pkg::ADC_W-1:0] pick_offset(input bit wide);
    int v;
    if (wide) return adc_avg_pkg::ADC_W'($urandom);
    v = int'($urandom_range(0, 100000)) - 50000;
    return v[adc_avg_pkg::ADC_W-1:0];
  endfunction

  task automatic random_settings(input bit wide);
    int up;
    up = $urandom_range(1000, 8000000);
    cfg_write(adc_avg_pkg::REG_ZERO_OFF0, pick_offset(wide));
    cfg_write(adc_avg_pkg::REG_ZERO_OFF1, pick_offset(wide));
    cfg_write(adc_avg_pkg::REG_ZERO_OFF2, pick_offset(wide));
    cfg_write(adc_avg_pkg::REG_ZERO_OFF3, pick_offset(wide));
    cfg_write(adc_avg_pkg::REG_AUTO_MODE,
              adc_avg_pkg::ADC_W'($urandom_range(0, 4) != 0));
    cfg_write(adc_avg_pkg::REG_MANUAL_RANGE, adc_avg_pkg::ADC_W'($urandom_range(0, 3)));
    cfg_write(adc_avg_pkg::REG_UP_THR, adc_avg_pkg::ADC_W'(up));
    cfg_write(adc_avg_pkg::REG_DOWN_THR, adc_avg_pkg::ADC_W'($urandom_range(0, up / 2)));
    settings_used++;
  endtask

  // slowly drifting signal with noise, level jumps and stray codes
  task automatic queue_signal(input int n_items);
    int level, code, k;
    level = $urandom_range(0, CODE_MAX);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 29) == 0) level = $urandom_range(0, CODE_MAX);
      else level = level + int'($urandom_range(0, 400)) - 200;
      if ($urandom_range(0, 49) == 0) code = $urandom_range(0, CODE_MAX);
      else code = level + int'($urandom_range(0, 6000)) - 3000;
      if (code < 0) code = 0;
      else if (code > int'(CODE_MAX)) code = CODE_MAX;
      code_q.push_back(code[adc_avg_pkg::ADC_W-1:0]);
    end
  endtask

  initial begin
    int p;
    foreach (win[i]) win[i] = 0;
    foreach (zoff[i]) zoff[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: jump limit edges, full scale, ranging up and down
    code_q = '{24'h800000, 24'h802710, 24'h804E21, 24'h804E20, CODE_MAX, CODE_MAX,
               CODE_MAX, CODE_MAX, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h800001,
               24'h800000};
    settings_used++;
    wait_idle();

    // range held, extreme offsets and thresholds, unused indexes
    cfg_write(adc_avg_pkg::REG_AUTO_MODE, '0);
    cfg_write(adc_avg_pkg::REG_MANUAL_RANGE, adc_avg_pkg::ADC_W'(adc_avg_pkg::RANGE_TOP));
    cfg_write(adc_avg_pkg::REG_ZERO_OFF0, 24'h800000);
    cfg_write(adc_avg_pkg::REG_ZERO_OFF1, 24'h7FFFFF);
    cfg_write(adc_avg_pkg::REG_ZERO_OFF2, 24'h000001);
    cfg_write(adc_avg_pkg::REG_ZERO_OFF3, 24'h800000);
    cfg_write(adc_avg_pkg::REG_UP_THR, CODE_MAX);
    cfg_write(adc_avg_pkg::REG_DOWN_THR, '0);
    cfg_write(REG_UNUSED_LO, 24'h123456);
    cfg_write(REG_UNUSED_HI, CODE_MAX);
    code_q = '{24'h000000, CODE_MAX, 24'h800000, 24'h7FFFFF};
    settings_used++;
    wait_idle();

    // up and down both hit on each item
    cfg_write(adc_avg_pkg::REG_AUTO_MODE, 24'd1);
    cfg_write(adc_avg_pkg::REG_ZERO_OFF3, 24'h7FFFFF);
    cfg_write(adc_avg_pkg::REG_UP_THR, '0);
    cfg_write(adc_avg_pkg::REG_DOWN_THR, CODE_MAX);
    cfg_write(adc_avg_pkg::REG_MANUAL_RANGE, 24'd1);
    code_q = '{24'h800000, CODE_MAX};
    wait_idle();
    cfg_write(adc_avg_pkg::REG_MANUAL_RANGE, adc_avg_pkg::ADC_W'(adc_avg_pkg::RANGE_TOP));
    code_q = '{24'h000000, CODE_MAX};
    wait_idle();
    cfg_write(adc_avg_pkg::REG_MANUAL_RANGE, '0);
    code_q = '{24'hC00000, 24'h400000};
    settings_used++;
    wait_idle();

    for (p = 0; p < 6; p++) begin
      random_settings(p == 2);
      queue_signal(305);
      if (p == 1 || p == 4) hold_reqs++;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("tb_top: %0d items checked over %0d register settings", items_checked,
             settings_used);
    $display("tb_top: %0d range steps, %0d long output hold-offs", range_steps, holds_done);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
